>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker of the bitmap allocator.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bia_pkg.sv
// Shared types and constants of the bitmap ID allocator.
// Depends on nothing; every file but assert_macros.svh imports it.
`default_nettype none

package bia_pkg;

   // Bitmap word geometry
   localparam int WORD_BITS = 32;
   localparam int BIT_W     = 5;

   // Payload widths
   localparam int CODE_W = 12;
   localparam int OUT_W  = 11;
   localparam int REL_W  = 18;

   // Request kinds
   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef logic [1:0] status_type;

   // Response status codes
   localparam status_type STATUS_ALLOC    = 2'd0;
   localparam status_type STATUS_FULL     = 2'd1;
   localparam status_type STATUS_RELEASED = 2'd2;
   localparam status_type STATUS_IGNORED  = 2'd3;

   typedef logic [WORD_BITS-1:0] word_type;

   // Result of the free-slot search over one bitmap word
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] idx;
   } find_type;

endpackage

`default_nettype wire

>>> hw/rtl/bia_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on bia_pkg for payload widths and types.
`default_nettype none

interface bia_req_if;
   import bia_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [CODE_W-1:0] code;

   modport source (output valid, kind, code, input ready);
   modport sink   (input valid, kind, code, output ready);
endinterface

interface bia_rsp_if;
   import bia_pkg::*;

   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] code_out;
   status_type       status;

   modport source (output valid, code_out, status, input ready);
   modport sink   (input valid, code_out, status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bitmap_id_allocator_unit.sv
// Release reads the code's bitmap word and writes it back with the bit cleared; an out-of-range
// code gets IGNORED without a bitmap access. Allocate checks the hint's word, else scans the words
// below the limit (read, then check), else grows the limit by CHUNK or answers FULL. Only one item
// is in flight: req_chan.ready is high only when idle. After reset a clearing pass writes every
// bitmap word with req_chan.ready low; hint and grown limit reset to zero.
`default_nettype none

module bitmap_id_allocator_unit #(
   parameter int CAPACITY  = 1024,
   parameter int CHUNK     = 256,
   parameter int CODE_BASE = 1000
) (
   input  wire              clock,
   input  wire              reset,
   bia_req_if.sink          req_chan,
   bia_rsp_if.source        rsp_chan
);
   import bia_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int HINT_W = $clog2(CAPACITY + 1);
   localparam int GROW_W = $clog2(CAPACITY + CHUNK + 1);
   localparam int NWORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W = SLOT_W - BIT_W;
   localparam int LW_W   = HINT_W - BIT_W;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_REL_WR  = 3'd2;
   localparam logic [2:0] ST_HINT_CK = 3'd3;
   localparam logic [2:0] ST_SCAN_RD = 3'd4;
   localparam logic [2:0] ST_SCAN_CK = 3'd5;
   localparam logic [2:0] ST_GROW    = 3'd6;
   localparam logic [2:0] ST_GROW_WR = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [WIDX_W-1:0] clr_ff, clr_in;
   logic [HINT_W-1:0] hint_ff, hint_in;
   logic [HINT_W-1:0] limit_ff, limit_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WIDX_W-1:0] addr_ff, addr_in;
   logic [LW_W-1:0]   left_ff, left_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_code_ff, rsp_code_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              req_fire;
   logic [REL_W-1:0]  rel_diff;
   logic              rel_ok;
   logic              hint_ok;
   logic [LW_W-1:0]   scan_lim;
   logic [LW_W-1:0]   start_raw;
   logic [WIDX_W-1:0] scan_start;
   logic [LW_W-1:0]   addr_inc;
   logic [GROW_W-1:0] grow_sum;
   logic              grow_full;

   logic              wr_en;
   logic [WIDX_W-1:0] wr_addr;
   word_type          wr_data;
   logic              rd_en;
   logic [WIDX_W-1:0] rd_addr;
   word_type          rd_data;
   find_type          find;

   logic              grant_en;
   logic [SLOT_W-1:0] grant_slot;

   bia_bitmap_ram #(
      .DEPTH  (NWORDS),
      .ADDR_W (WIDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bia_zero_find u_find (
      .word   (rd_data),
      .result (find)
   );

   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Range check of a released code
   assign rel_diff = REL_W'(req_chan.code) - REL_W'(CODE_BASE);
   assign rel_ok   = (REL_W'(req_chan.code) >= REL_W'(CODE_BASE))
                     && (rel_diff < REL_W'(CAPACITY));

   // Scan window: whole words below the limit, starting at the hint's word, else at word zero
   assign hint_ok    = hint_ff < limit_ff;
   assign scan_lim   = limit_ff[HINT_W-1:BIT_W];
   assign start_raw  = hint_ok ? hint_ff[HINT_W-1:BIT_W] : '0;
   assign scan_start = (start_raw < scan_lim) ? WIDX_W'(start_raw) : '0;
   assign addr_inc   = LW_W'(addr_ff) + LW_W'(1);

   assign grow_sum  = GROW_W'(limit_ff) + GROW_W'(CHUNK);
   assign grow_full = grow_sum > GROW_W'(CAPACITY);

   // Sequencer: read a word, check it, write it back
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      hint_in       = hint_ff;
      limit_in      = limit_ff;
      slot_in       = slot_ff;
      addr_in       = addr_ff;
      left_in       = left_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_code_in   = rsp_code_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff[SLOT_W-1:BIT_W];
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      grant_en      = 1'b0;
      grant_slot    = slot_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + WIDX_W'(1);
            if (clr_ff == WIDX_W'(NWORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.kind == KIND_RELEASE) begin
                  if (rel_ok) begin
                     slot_in  = rel_diff[SLOT_W-1:0];
                     rd_en    = 1'b1;
                     rd_addr  = rel_diff[SLOT_W-1:BIT_W];
                     state_in = ST_REL_WR;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_code_in   = '0;
                     rsp_status_in = STATUS_IGNORED;
                  end
               end else if (hint_ok) begin
                  slot_in  = SLOT_W'(hint_ff);
                  rd_en    = 1'b1;
                  rd_addr  = hint_ff[SLOT_W-1:BIT_W];
                  state_in = ST_HINT_CK;
               end else begin
                  addr_in  = scan_start;
                  left_in  = scan_lim;
                  state_in = (scan_lim == '0) ? ST_GROW : ST_SCAN_RD;
               end
            end
         end
         ST_REL_WR: begin
            wr_en         = 1'b1;
            wr_data       = rd_data & ~(WORD_BITS'(1) << slot_ff[BIT_W-1:0]);
            rsp_valid_in  = 1'b1;
            rsp_code_in   = '0;
            rsp_status_in = STATUS_RELEASED;
            state_in      = ST_IDLE;
         end
         ST_HINT_CK: begin
            if (!rd_data[slot_ff[BIT_W-1:0]]) begin
               grant_en = 1'b1;
            end else begin
               addr_in  = scan_start;
               left_in  = scan_lim;
               state_in = (scan_lim == '0) ? ST_GROW : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = addr_ff;
            state_in = ST_SCAN_CK;
         end
         ST_SCAN_CK: begin
            if (find.found) begin
               grant_en   = 1'b1;
               grant_slot = {addr_ff, find.idx};
            end else if (left_ff == LW_W'(1)) begin
               state_in = ST_GROW;
            end else begin
               left_in  = left_ff - LW_W'(1);
               addr_in  = (addr_inc == scan_lim) ? '0 : WIDX_W'(addr_inc);
               state_in = ST_SCAN_RD;
            end
         end
         ST_GROW: begin
            if (grow_full) begin
               rsp_valid_in  = 1'b1;
               rsp_code_in   = '0;
               rsp_status_in = STATUS_FULL;
               state_in      = ST_IDLE;
            end else begin
               slot_in  = SLOT_W'(limit_ff);
               rd_en    = 1'b1;
               rd_addr  = limit_ff[SLOT_W-1:BIT_W];
               state_in = ST_GROW_WR;
            end
         end
         ST_GROW_WR: begin
            grant_en = 1'b1;
            limit_in = HINT_W'(grow_sum);
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Mark the granted slot taken, advance the hint, post the code
      if (grant_en) begin
         wr_en         = 1'b1;
         wr_addr       = grant_slot[SLOT_W-1:BIT_W];
         wr_data       = rd_data | (WORD_BITS'(1) << grant_slot[BIT_W-1:0]);
         hint_in       = HINT_W'(grant_slot) + HINT_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_code_in   = OUT_W'(CODE_BASE) + OUT_W'(grant_slot);
         rsp_status_in = STATUS_ALLOC;
         state_in      = ST_IDLE;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hint_ff      <= '0;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hint_ff      <= hint_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and response payload registers
   always_ff @(posedge clock) begin
      slot_ff       <= slot_in;
      addr_ff       <= addr_in;
      left_ff       <= left_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.code_out = rsp_code_ff;
   assign rsp_chan.status   = rsp_status_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bia_bitmap_ram.sv
// Occupancy bitmap storage: one write port, one read port, registered read.
// Depends on bia_pkg for the word type.
`default_nettype none

module bia_bitmap_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  wire                    clock,
   input  wire                    wr_en,
   input  wire [ADDR_W-1:0]       wr_addr,
   input  bia_pkg::word_type      wr_data,
   input  wire                    rd_en,
   input  wire [ADDR_W-1:0]       rd_addr,
   output bia_pkg::word_type      rd_data
);
   import bia_pkg::*;

   word_type mem [DEPTH];
   word_type rd_data_ff;

   // Write the addressed word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bia_zero_find.sv
// Lowest clear bit search over one bitmap word.
// Depends on bia_pkg for the word and result types.
`default_nettype none

module bia_zero_find (
   input  bia_pkg::word_type word,
   output bia_pkg::find_type result
);
   import bia_pkg::*;

   word_type         free_bits;
   word_type         lowest;
   logic [BIT_W-1:0] idx;

   // Isolate the lowest free bit as a one-hot mask
   assign free_bits = ~word;
   assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));

   // Encode the one-hot mask
   always_comb begin
      idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         idx = idx | (lowest[i] ? BIT_W'(i) : BIT_W'(0));
      end
   end

   assign result.found = |free_bits;
   assign result.idx   = idx;

endmodule

`default_nettype wire

>>> hw/rtl/bia_checker.sv
// Port-level checks of the bitmap ID allocator, bound to the top level.
// Depends on bia_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module bia_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_valid,
   input wire                      req_ready,
   input wire                      rsp_valid,
   input wire                      rsp_ready,
   input wire [bia_pkg::OUT_W-1:0] rsp_code_out,
   input wire [1:0]                rsp_status
);
   import bia_pkg::*;

   logic req_xfer;
   logic rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // Hold off requests during the clearing pass after reset
   `ASSERT_NEXT_ALWAYS(a_clear_blocks, clock, reset, !req_ready, "request taken during clear")

   // Keep one item in flight: a second transfer needs the first result gone
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_xfer, !req_xfer || rsp_xfer, "overlapping items")

   // Hold a stalled response
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code_out) && $stable(rsp_status), "stalled response changed")

   // Drive a zero code on every non-allocate response
   `ASSERT_IMPLY(a_zero_code, clock, reset, rsp_valid && rsp_status != STATUS_ALLOC, rsp_code_out == '0, "nonzero code without allocation")

endmodule

bind bitmap_id_allocator_unit bia_checker u_bia_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_code_out (rsp_chan.code_out),
   .rsp_status   (rsp_chan.status)
);

`default_nettype wire
